>>> hw/rtl/glep_pkg.sv
// Shared types, constants and functions for the gradient line endpoint unit.
package glep_pkg;

    localparam int AngleW   = 32;
    localparam int DimW     = 24;
    localparam int XyW      = 27;
    localparam int LenW     = 26;
    localparam int RemW     = 25;           // reduced angle, Q16 degrees, below 360
    localparam int ZW       = 32;           // CORDIC angle, Q24 degrees
    localparam int TrigW    = 34;           // Q30 sine and cosine with headroom
    localparam int KW       = 34;           // k, signed integer (Q0)
    localparam int MaxSteps = 32;
    localparam int DefSteps = 16;

    localparam logic [RemW-1:0] Quarter   = RemW'(90 * 65536);
    localparam logic [RemW-1:0] HalfTurn  = RemW'(180 * 65536);
    localparam logic [RemW-1:0] ThreeQ    = RemW'(270 * 65536);
    localparam longint          FullTurn  = 360 * 65536;
    localparam logic signed [TrigW-1:0] OneQ30 = TrigW'(64'sd1 << 30);

    typedef struct packed {
        logic [1:0]      quad;
        logic            axis;      // remainder within quadrant is zero
        logic            neg_w;
        logic            neg_h;
        logic [ZW-1:0]   z;         // remainder in Q24 degrees
        logic [DimW-1:0] w;
        logic [DimW-1:0] h;
    } glep_item_t;

    typedef struct packed {
        logic signed [XyW-1:0] end_x;
        logic signed [XyW-1:0] end_y;
        logic [LenW-1:0]       line_length;
    } glep_result_t;

    function automatic logic signed [ZW-1:0] atan_q24(input int i);
        logic signed [ZW-1:0] t [MaxSteps] = '{
            754974720, 445687602, 235489088, 119537938,
            60000934, 30029717, 15018523, 7509720,
            3754917, 1877466, 938734, 469367,
            234684, 117342, 58671, 29335,
            14668, 7334, 3667, 1833,
            917, 458, 229, 115,
            57, 29, 14, 7,
            4, 2, 1, 0};
        return t[i];
    endfunction

    // Elaboration-time root of prod(1 + 2^-2i) in Q60; the gain is 2^60 over it.
    function automatic longint unsigned cordic_root(input int n);
        longint unsigned p;
        longint unsigned v;
        longint unsigned r;
        longint unsigned b;
        p = 64'd1 << 60;
        for (int i = 0; i < n; i++) p = p + (p >> (2 * i));
        v = p;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/glep_front.sv
// Front stages: angle reduction, quadrant and corner classification.
module glep_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [glep_pkg::AngleW-1:0]  angle_deg,
    input  logic [glep_pkg::DimW-1:0]    box_width,
    input  logic [glep_pkg::DimW-1:0]    box_height,
    output logic                         item_valid,
    input  logic                         item_ready,
    output glep_pkg::glep_item_t         item
);
    import glep_pkg::*;

    // a full turn in Q16 is 45 * 2^19, so only the bits from 19 up need reducing
    localparam logic [13:0] TurnHi   = 14'd45;
    localparam logic [13:0] HiBias   = 14'd4140;     // 92 turns, lifts the top bits above zero
    localparam logic [27:0] RecipMul = 28'd11651;    // ceil(2^19 / 45)

    // stage 1: remainder modulo a full turn
    logic                 s1_valid_reg;
    logic [RemW-1:0]      s1_rem_reg;
    logic [DimW-1:0]      s1_w_reg;
    logic [DimW-1:0]      s1_h_reg;
    logic                 s1_adv;
    logic [13:0]          hi_off;
    logic [27:0]          hi_prod;
    logic [8:0]           hi_quot;
    logic [5:0]           rem_hi;
    logic [RemW-1:0]      rem_next;

    // stage 2: classified item
    logic                 s2_valid_reg;
    glep_item_t           s2_item_reg;
    glep_item_t           s2_item_next;
    logic                 s2_adv;
    logic [RemW-1:0]      r_part;

    assign s2_adv   = !s2_valid_reg || item_ready;
    assign s1_adv   = !s1_valid_reg || s2_adv;
    assign in_ready = s1_adv;

    // Reduce the top 13 bits modulo 45 by reciprocal multiplication; keep the low 19.
    assign hi_off   = {angle_deg[AngleW-1], angle_deg[AngleW-1:19]} + HiBias;
    assign hi_prod  = 28'(hi_off) * RecipMul;
    assign hi_quot  = hi_prod[27:19];
    assign rem_hi   = 6'(hi_off - 14'(hi_quot) * TurnHi);
    assign rem_next = {rem_hi, angle_deg[18:0]};

    always_comb begin
        s2_item_next = '0;
        if (s1_rem_reg >= ThreeQ) begin
            s2_item_next.quad = 2'd3;
            r_part = s1_rem_reg - ThreeQ;
        end else if (s1_rem_reg >= HalfTurn) begin
            s2_item_next.quad = 2'd2;
            r_part = s1_rem_reg - HalfTurn;
        end else if (s1_rem_reg >= Quarter) begin
            s2_item_next.quad = 2'd1;
            r_part = s1_rem_reg - Quarter;
        end else begin
            s2_item_next.quad = 2'd0;
            r_part = s1_rem_reg;
        end
        s2_item_next.axis  = (r_part == '0);
        s2_item_next.z     = {ZW'(r_part)} << 8;
        s2_item_next.neg_w = s1_rem_reg > HalfTurn;
        s2_item_next.neg_h = (s1_rem_reg < Quarter) || (s1_rem_reg > ThreeQ);
        s2_item_next.w     = s1_w_reg;
        s2_item_next.h     = s1_h_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            if (s1_adv) s1_valid_reg <= in_valid;
            if (s2_adv) s2_valid_reg <= s1_valid_reg;
        end
        if (s1_adv) begin
            s1_rem_reg <= rem_next;
            s1_w_reg   <= box_width;
            s1_h_reg   <= box_height;
        end
        if (s2_adv) s2_item_reg <= s2_item_next;
    end

    assign item_valid = s2_valid_reg;
    assign item       = s2_item_reg;

`ifndef SYNTH
    a_rem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg |-> s1_rem_reg < RemW'(FullTurn))
        else $error("reduced angle out of range");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s2_valid_reg && !item_ready) |=> $stable(s2_item_reg))
        else $error("classified item changed while stalled");
    a_axis: assert property (@(posedge aclk) disable iff (!aresetn)
        s2_valid_reg && s2_item_reg.axis |-> s2_item_reg.z == '0)
        else $error("axis flag without zero remainder");
`endif
endmodule

>>> hw/rtl/glep_queue.sv
// Short queue between the front and back parts.
module glep_queue #(
    parameter int Depth = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_valid,
    output logic                  wr_ready,
    input  glep_pkg::glep_item_t  wr_item,
    output logic                  rd_valid,
    input  logic                  rd_ready,
    output glep_pkg::glep_item_t  rd_item
);
    import glep_pkg::*;

    localparam int AW = $clog2(Depth);

    glep_item_t        mem_reg [Depth];
    logic [AW-1:0]     wp_reg, wp_next;
    logic [AW-1:0]     rp_reg, rp_next;
    logic [AW:0]       cnt_reg, cnt_next;
    logic              wr_fire, rd_fire;

    assign wr_ready = cnt_reg != (AW+1)'(Depth);
    assign rd_valid = cnt_reg != '0;
    assign rd_item  = mem_reg[rp_reg];
    assign wr_fire  = wr_valid && wr_ready;
    assign rd_fire  = rd_valid && rd_ready;

    always_comb begin
        wp_next  = wr_fire ? ((wp_reg == AW'(Depth-1)) ? '0 : wp_reg + 1'b1) : wp_reg;
        rp_next  = rd_fire ? ((rp_reg == AW'(Depth-1)) ? '0 : rp_reg + 1'b1) : rp_reg;
        cnt_next = cnt_reg + (AW+1)'(wr_fire) - (AW+1)'(rd_fire);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
        if (wr_fire) mem_reg[wp_reg] <= wr_item;
    end

`ifndef SYNTH
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= (AW+1)'(Depth))
        else $error("queue count overflow");
    a_track: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_fire && !rd_fire) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue count lost a write");
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == '0) |-> wp_reg == rp_reg)
        else $error("empty queue with unequal pointers");
`endif
endmodule

>>> hw/rtl/glep_back.sv
// Back part: pipelined CORDIC, projection and saturation.
module glep_back #(
    parameter int CordicSteps = glep_pkg::DefSteps
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     item_valid,
    output logic                     item_ready,
    input  glep_pkg::glep_item_t     item,
    output logic                     res_valid,
    input  logic                     res_ready,
    output glep_pkg::glep_result_t   res
);
    import glep_pkg::*;

    localparam int N    = (CordicSteps > MaxSteps) ? MaxSteps : CordicSteps;
    localparam int Post = 5;
    localparam int NS   = N + Post;
    localparam longint unsigned Root = cordic_root(N);
    localparam logic signed [TrigW-1:0] Gain = TrigW'(((64'd1 << 60) + Root / 2) / Root);
    localparam int PW   = TrigW + DimW + 2;   // product width
    localparam int XPW  = KW + TrigW;

    logic               adv;
    logic [NS-1:0]      v_reg;
    glep_item_t         it_reg [1:N];
    logic signed [TrigW-1:0] cx_reg [1:N];
    logic signed [TrigW-1:0] cy_reg [1:N];
    logic signed [ZW-1:0]    cz_reg [1:N];

    // stage A: quadrant mapping
    logic signed [TrigW-1:0] sa_s_reg, sa_c_reg, c0, s0, sm, cm;
    logic signed [DimW:0]    sa_w_reg, sa_h_reg;
    // stage B: products
    logic signed [PW-1:0]    sb_hc_reg, sb_ws_reg;
    logic signed [TrigW-1:0] sb_s_reg, sb_c_reg;
    // stage C: k rounded
    logic signed [KW-1:0]    sc_k_reg;
    logic signed [TrigW-1:0] sc_s_reg, sc_c_reg;
    logic signed [PW:0]      kfull;
    // stage D: end products
    logic signed [XPW-1:0]   sd_x_reg, sd_y_reg;
    logic signed [KW-1:0]    sd_k_reg;
    // stage E: output
    glep_result_t            se_res_reg, se_res_next;
    logic signed [XPW-30:0]  xr, yr;
    logic [KW-1:0]           ka;

    assign adv        = !v_reg[NS-1] || res_ready;
    assign item_ready = adv;
    assign res_valid  = v_reg[NS-1];
    assign res        = se_res_reg;

    for (genvar i = 0; i < N; i++) begin : g_cordic
        logic signed [TrigW-1:0] xin, yin, xs, ys;
        logic signed [ZW-1:0]    zin;
        glep_item_t              iin;
        if (i == 0) begin : g_head
            assign xin = Gain;
            assign yin = '0;
            assign zin = $signed(item.z);
            assign iin = item;
        end else begin : g_body
            assign xin = cx_reg[i];
            assign yin = cy_reg[i];
            assign zin = cz_reg[i];
            assign iin = it_reg[i];
        end
        assign xs = xin >>> i;
        assign ys = yin >>> i;
        always_ff @(posedge aclk) begin
            if (adv) begin
                it_reg[i+1] <= iin;
                if (!zin[ZW-1]) begin
                    cx_reg[i+1] <= xin - ys;
                    cy_reg[i+1] <= yin + xs;
                    cz_reg[i+1] <= zin - atan_q24(i);
                end else begin
                    cx_reg[i+1] <= xin + ys;
                    cy_reg[i+1] <= yin - xs;
                    cz_reg[i+1] <= zin + atan_q24(i);
                end
            end
        end
    end

    always_comb begin
        c0 = it_reg[N].axis ? OneQ30 : cx_reg[N];
        s0 = it_reg[N].axis ? '0 : cy_reg[N];
        case (it_reg[N].quad)
            2'd0:    begin sm = s0;  cm = c0;  end
            2'd1:    begin sm = c0;  cm = -s0; end
            2'd2:    begin sm = -s0; cm = -c0; end
            default: begin sm = -c0; cm = s0;  end
        endcase
    end

    assign kfull = (PW+1)'(sb_hc_reg) - (PW+1)'(sb_ws_reg) + (PW+1)'(64'sd1 << 29);
    assign xr = sd_x_reg[XPW-1:29] + 1'b1;
    assign yr = sd_y_reg[XPW-1:29] + 1'b1;
    assign ka = sd_k_reg[KW-1] ? KW'(-sd_k_reg) : KW'(sd_k_reg);

    // round_q30 = floor((v + 2^29) / 2^30) = floor((floor(v/2^29) + 1) / 2)
    always_comb begin
        logic signed [XPW-30:0] xq, yq;
        xq = xr >>> 1;
        yq = yr >>> 1;
        if (xq > (XPW-29)'(64'sd67108863)) se_res_next.end_x = XyW'(67108863);
        else if (xq < -(XPW-29)'(64'sd67108864)) se_res_next.end_x = XyW'(-67108864);
        else se_res_next.end_x = XyW'(xq);
        if (yq > (XPW-29)'(64'sd67108863)) se_res_next.end_y = XyW'(67108863);
        else if (yq < -(XPW-29)'(64'sd67108864)) se_res_next.end_y = XyW'(-67108864);
        else se_res_next.end_y = XyW'(yq);
        se_res_next.line_length = (ka > KW'(67108863)) ? LenW'(67108863) : LenW'(ka);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[NS-2:0], item_valid};
        end
        if (adv) begin
            sa_s_reg  <= sm;
            sa_c_reg  <= cm;
            sa_w_reg  <= it_reg[N].neg_w ? -$signed({1'b0, it_reg[N].w})
                                         : $signed({1'b0, it_reg[N].w});
            sa_h_reg  <= it_reg[N].neg_h ? -$signed({1'b0, it_reg[N].h})
                                         : $signed({1'b0, it_reg[N].h});
            sb_hc_reg <= PW'(sa_h_reg * sa_c_reg);
            sb_ws_reg <= PW'(sa_w_reg * sa_s_reg);
            sb_s_reg  <= sa_s_reg;
            sb_c_reg  <= sa_c_reg;
            sc_k_reg  <= KW'(kfull >>> 30);
            sc_s_reg  <= sb_s_reg;
            sc_c_reg  <= sb_c_reg;
            sd_x_reg  <= XPW'(-(sc_k_reg * sc_s_reg));
            sd_y_reg  <= XPW'(sc_k_reg * sc_c_reg);
            sd_k_reg  <= sc_k_reg;
            se_res_reg <= se_res_next;
        end
    end

`ifndef SYNTH
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && !res_ready) |=> $stable(se_res_reg))
        else $error("result changed while stalled");
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && !res_ready) |=> $stable(v_reg))
        else $error("pipeline moved under stall");
    a_len: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && se_res_reg.line_length == '0 |->
            se_res_reg.end_x == '0 && se_res_reg.end_y == '0)
        else $error("zero length with nonzero end vector");
`endif
endmodule

>>> hw/rtl/gradient_line_endpoint_unit.sv
// Top level of the gradient line endpoint unit.
//   channel | dir | tdata (low bit up)                        | tuser / tlast
//   s_      | in  | angle_deg[31:0] box_width[55:32] box_height[79:56] | none
//   m_      | out | end_x[26:0] end_y[53:27] line_length[79:54]         | none
// One transfer per cycle sustained while m_tready is high; items pass the front
// stages, the queue, the CORDIC stages (one iteration each) and back stages A-E.
// aresetn is synchronous and clears all valid flags and queue pointers.
// A stall on m_ freezes the back pipeline; the queue and the front stages then
// fill before s_tready drops.
module gradient_line_endpoint_unit #(
    parameter int CORDIC_STEPS = glep_pkg::DefSteps
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // angle_deg, box_width, box_height
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata    // end_x, end_y, line_length
);
    import glep_pkg::*;

    logic         f_valid, f_ready, q_valid, q_ready;
    glep_item_t   f_item, q_item;
    glep_result_t res;

    glep_front u_front (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready),
        .angle_deg(s_tdata[31:0]), .box_width(s_tdata[55:32]),
        .box_height(s_tdata[79:56]),
        .item_valid(f_valid), .item_ready(f_ready), .item(f_item)
    );

    glep_queue #(.Depth(4)) u_queue (
        .aclk, .aresetn,
        .wr_valid(f_valid), .wr_ready(f_ready), .wr_item(f_item),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_item(q_item)
    );

    glep_back #(.CordicSteps(CORDIC_STEPS)) u_back (
        .aclk, .aresetn,
        .item_valid(q_valid), .item_ready(q_ready), .item(q_item),
        .res_valid(m_tvalid), .res_ready(m_tready), .res(res)
    );

    assign m_tdata = {res.line_length, res.end_y, res.end_x};
endmodule
